### rtl/bcp_pkg.sv
package bcp_pkg;

  // result kinds, carried in out_tuser[1:0]
  typedef enum logic [1:0] {
    KIND_INFO = 2'd0,
    KIND_ENH  = 2'd1,
    KIND_TEXT = 2'd2,
    KIND_EOF  = 2'd3
  } kind_t;

  // progress through one cost line
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_BLANK = 2'd1,
    PH_NUM   = 2'd2,
    PH_JUNK  = 2'd3
  } phase_t;

  // file sections
  localparam logic [1:0] SEC_INFO = 2'd0;
  localparam logic [1:0] SEC_ENH  = 2'd1;
  localparam logic [1:0] SEC_TEXT = 2'd2;

  localparam int IDX_W   = 5;
  localparam int COST_W  = 24;
  localparam int BURST_N = 5;

  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [COST_W-1:0] COST_MAX = 24'h7FFFFF;
  localparam logic [COST_W-1:0] ACC_SAT  = 24'h800000;

  // code points for bytes 0x80..0xFF
  localparam logic [15:0] UPPER_MAP [0:127] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

endpackage

### rtl/briefing_cost_parser_cp437_utf8_core.sv
// Briefing file parser with CP437 to UTF-8 text output.
// Input stream: one file byte per transfer on in_tdata[7:0]; in_tlast marks the
// final byte of the file, which is consumed but produces only the end marker.
// Output stream: 0 to 5 results per input byte (costs, UTF-8 text bytes, end of
// file). out_tlast is set on the last result caused by one input byte.
// Results of a byte appear on the cycle after its transfer, one per cycle
// while out_tready is high. An input byte that yields one result or none is
// taken every cycle while out_tready is high; a byte that yields a burst of N
// results holds in_tready low while the burst register drains them through
// the output port, one per cycle while out_tready is high. in_tready is high
// when the burst register is empty or its last result is being taken in the
// same cycle. Stall: when out_tready is low the current result holds on the
// port and no new byte is taken while the burst register holds results.
// Reset (rst_n low, synchronous): parser returns to the info cost section with
// all counts cleared and the burst register empty. After the end of file every
// further byte is taken and dropped until reset.
module briefing_cost_parser_cp437_utf8_core #(
  parameter int INFO_ENTRIES        = 8,
  parameter int ENHANCEMENT_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // file_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // entry_index[4:0], cost_value[28:5], utf8_byte[36:29], zero
  output logic [2:0]  out_tuser,  // item_kind[1:0], entry_dropped[2]
  output logic        out_tlast   // run_last
);

  localparam int IW = bcp_pkg::IDX_W;
  localparam int CW = bcp_pkg::COST_W;
  localparam logic [IW-1:0] INFO_BOUND = IW'(INFO_ENTRIES);
  localparam logic [IW-1:0] ENH_BOUND  = IW'(ENHANCEMENT_ENTRIES);

  // parser state
  logic [1:0]          sec_r, sec_nxt;
  logic                skip_r, skip_nxt;
  bcp_pkg::phase_t     phase_r, phase_nxt;
  logic                neg_r, neg_nxt;
  logic [CW-1:0]       acc_r, acc_nxt;
  logic [IW-1:0]       icnt_r, icnt_nxt;
  logic [IW-1:0]       ecnt_r, ecnt_nxt;
  logic [IW-1:0]       seg_r, seg_nxt;
  logic [1:0]          plf_r, plf_nxt;
  logic                done_r, done_nxt;

  // result burst
  bcp_pkg::kind_t      bkind_r, bkind_nxt;
  logic [IW-1:0]       bidx_r, bidx_nxt;
  logic [CW-1:0]       bcost_r, bcost_nxt;
  logic                bdrop_r, bdrop_nxt;
  logic [7:0]          bbytes_r [bcp_pkg::BURST_N];
  logic [7:0]          bbytes_nxt [bcp_pkg::BURST_N];
  logic [2:0]          bcnt_r, bcnt_nxt;
  logic [2:0]          bptr_r;

  logic                in_acc, out_acc, last_take;
  logic [7:0]          b;
  logic                is_digit, is_blank;
  logic [15:0]         u;
  logic [7:0]          enc [3];
  logic [2:0]          enc_n;
  logic [27:0]         mul;
  logic [CW-1:0]       acc_dig;
  logic [CW-1:0]       cost_v;

  assign b          = in_tdata;
  assign out_tvalid = (bcnt_r != 3'd0);
  assign out_acc    = out_tvalid && out_tready;
  assign last_take  = out_acc && (bptr_r == 3'(bcnt_r - 3'd1));
  assign in_tready  = !out_tvalid || last_take;
  assign in_acc     = in_tvalid && in_tready;

  assign out_tdata = {3'b000, bbytes_r[bptr_r], bcost_r, bidx_r};
  assign out_tuser = {bdrop_r, bkind_r};
  assign out_tlast = (bptr_r == 3'(bcnt_r - 3'd1));

  assign is_digit = (b >= bcp_pkg::CH_ZERO) && (b <= bcp_pkg::CH_NINE);
  assign is_blank = (b == bcp_pkg::CH_SPACE) || (b == bcp_pkg::CH_TAB) ||
                    (b == bcp_pkg::CH_VT) || (b == bcp_pkg::CH_FF) ||
                    (b == bcp_pkg::CH_CR);

  // acc * 10 + digit, saturated at the negative limit magnitude
  assign mul     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                 + {24'd0, 4'(b - bcp_pkg::CH_ZERO)};
  assign acc_dig = (mul > {4'd0, bcp_pkg::ACC_SAT}) ? bcp_pkg::ACC_SAT : mul[CW-1:0];

  assign cost_v = neg_r ? CW'(-acc_r)
                        : ((acc_r > bcp_pkg::COST_MAX) ? bcp_pkg::COST_MAX : acc_r);

  assign u = b[7] ? bcp_pkg::UPPER_MAP[b[6:0]] : {8'h00, b};

  always_comb begin
    enc[0] = 8'h00;
    enc[1] = 8'h00;
    enc[2] = 8'h00;
    if (u < 16'h0080) begin
      enc[0] = u[7:0];
      enc_n  = 3'd1;
    end else if (u < 16'h0800) begin
      enc[0] = {3'b110, u[10:6]};
      enc[1] = {2'b10, u[5:0]};
      enc_n  = 3'd2;
    end else begin
      enc[0] = {4'b1110, u[15:12]};
      enc[1] = {2'b10, u[11:6]};
      enc[2] = {2'b10, u[5:0]};
      enc_n  = 3'd3;
    end
  end

  always_comb begin
    sec_nxt   = sec_r;
    skip_nxt  = skip_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    icnt_nxt  = icnt_r;
    ecnt_nxt  = ecnt_r;
    seg_nxt   = seg_r;
    plf_nxt   = plf_r;
    done_nxt  = done_r;
    bkind_nxt = bcp_pkg::KIND_TEXT;
    bidx_nxt  = seg_r;
    bcost_nxt = '0;
    bdrop_nxt = 1'b0;
    bcnt_nxt  = 3'd0;
    for (int i = 0; i < bcp_pkg::BURST_N; i++) bbytes_nxt[i] = 8'h00;

    if (!done_r) begin
      if (in_tlast || (b == 8'h00 && !skip_r)) begin
        done_nxt  = 1'b1;
        bkind_nxt = bcp_pkg::KIND_EOF;
        bcnt_nxt  = 3'd1;
      end else if (skip_r) begin
        skip_nxt = 1'b0;
        if (sec_r == bcp_pkg::SEC_TEXT && seg_r <= icnt_r && icnt_r != '0) begin
          bbytes_nxt[0] = bcp_pkg::CH_LF;
          bcnt_nxt      = 3'd1;
        end
      end else if (sec_r != bcp_pkg::SEC_TEXT) begin
        if (phase_r == bcp_pkg::PH_START && b == bcp_pkg::CH_BAR) begin
          sec_nxt   = 2'(sec_r + 2'd1);
          skip_nxt  = 1'b1;
          phase_nxt = bcp_pkg::PH_START;
          neg_nxt   = 1'b0;
          acc_nxt   = '0;
        end else if (b == bcp_pkg::CH_LF) begin
          // emit the line's number
          bcnt_nxt  = 3'd1;
          bcost_nxt = cost_v;
          if (sec_r == bcp_pkg::SEC_INFO) begin
            bkind_nxt = bcp_pkg::KIND_INFO;
            if (icnt_r < INFO_BOUND) begin
              bidx_nxt = icnt_r;
              icnt_nxt = IW'(icnt_r + 1'b1);
            end else begin
              bidx_nxt  = INFO_BOUND;
              bdrop_nxt = 1'b1;
            end
          end else begin
            bkind_nxt = bcp_pkg::KIND_ENH;
            if (ecnt_r < ENH_BOUND) begin
              bidx_nxt = ecnt_r;
              ecnt_nxt = IW'(ecnt_r + 1'b1);
            end else begin
              bidx_nxt  = ENH_BOUND;
              bdrop_nxt = 1'b1;
            end
          end
          phase_nxt = bcp_pkg::PH_START;
          neg_nxt   = 1'b0;
          acc_nxt   = '0;
        end else if (phase_r == bcp_pkg::PH_START || phase_r == bcp_pkg::PH_BLANK) begin
          if (is_blank) begin
            phase_nxt = bcp_pkg::PH_BLANK;
          end else if (b == bcp_pkg::CH_PLUS) begin
            phase_nxt = bcp_pkg::PH_NUM;
          end else if (b == bcp_pkg::CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = bcp_pkg::PH_NUM;
          end else if (is_digit) begin
            acc_nxt   = acc_dig;
            phase_nxt = bcp_pkg::PH_NUM;
          end else begin
            phase_nxt = bcp_pkg::PH_JUNK;
          end
        end else if (phase_r == bcp_pkg::PH_NUM) begin
          if (is_digit) acc_nxt = acc_dig;
          else phase_nxt = bcp_pkg::PH_JUNK;
        end
      end else if (seg_r <= icnt_r) begin
        if (b == bcp_pkg::CH_BAR) begin
          plf_nxt  = 2'd0;
          seg_nxt  = IW'(seg_r + 1'b1);
          skip_nxt = 1'b1;
        end else if (u == {8'h00, bcp_pkg::CH_LF}) begin
          if (plf_r < 2'd2) plf_nxt = 2'(plf_r + 2'd1);
        end else begin
          // flush pending line feeds (a single one as a space), then the encoded character
          plf_nxt = 2'd0;
          if (plf_r == 2'd0) begin
            for (int i = 0; i < 3; i++) bbytes_nxt[i] = enc[i];
            bcnt_nxt = enc_n;
          end else if (plf_r == 2'd1) begin
            bbytes_nxt[0] = bcp_pkg::CH_SPACE;
            for (int i = 0; i < 3; i++) bbytes_nxt[i+1] = enc[i];
            bcnt_nxt = 3'(enc_n + 3'd1);
          end else begin
            bbytes_nxt[0] = bcp_pkg::CH_LF;
            bbytes_nxt[1] = bcp_pkg::CH_LF;
            for (int i = 0; i < 3; i++) bbytes_nxt[i+2] = enc[i];
            bcnt_nxt = 3'(enc_n + 3'd2);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= bcp_pkg::SEC_INFO;
      skip_r  <= 1'b0;
      phase_r <= bcp_pkg::PH_START;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      icnt_r  <= '0;
      ecnt_r  <= '0;
      seg_r   <= '0;
      plf_r   <= 2'd0;
      done_r  <= 1'b0;
      bcnt_r  <= 3'd0;
      bptr_r  <= 3'd0;
    end else begin
      if (in_acc) begin
        sec_r   <= sec_nxt;
        skip_r  <= skip_nxt;
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
        icnt_r  <= icnt_nxt;
        ecnt_r  <= ecnt_nxt;
        seg_r   <= seg_nxt;
        plf_r   <= plf_nxt;
        done_r  <= done_nxt;
        bcnt_r  <= bcnt_nxt;
        bptr_r  <= 3'd0;
      end else if (last_take) begin
        bcnt_r <= 3'd0;
        bptr_r <= 3'd0;
      end else if (out_acc) begin
        bptr_r <= 3'(bptr_r + 3'd1);
      end
    end
  end

  // burst payload, loaded with each accepted byte
  always_ff @(posedge clk) begin
    if (in_acc) begin
      bkind_r <= bkind_nxt;
      bidx_r  <= bidx_nxt;
      bcost_r <= bcost_nxt;
      bdrop_r <= bdrop_nxt;
      for (int i = 0; i < bcp_pkg::BURST_N; i++) bbytes_r[i] <= bbytes_nxt[i];
    end
  end

endmodule
